[src/mbsed_pkg.sv]
package mbsed_pkg;

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_NOTE_ON     = 3'd1,
    KIND_NOTE_OFF    = 3'd2,
    KIND_SUSTAIN_ON  = 3'd3,
    KIND_SUSTAIN_OFF = 3'd4,
    KIND_ALL_OFF     = 3'd5
  } kind_e;

  // Status bytes with special meaning
  localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
  localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
  localparam logic [7:0] BYTE_COMMON_MIN   = 8'hF1;

  // Message types (high nibble of the status byte)
  localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
  localparam logic [3:0] TYPE_CTRL      = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM   = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE  = 4'hD;

  localparam logic [6:0] CTRL_SUSTAIN   = 7'd64;
  localparam logic [6:0] CTRL_ALL_OFF   = 7'd123;
  localparam logic [6:0] SUSTAIN_ON_MIN = 7'd64;

  localparam logic [15:0] CHANNEL_MASK_RESET = 16'hFFFF;

  typedef struct packed {
    kind_e      event_kind;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
    logic [3:0] event_channel;
  } evt_t;

endpackage

[src/mbsed_intf.sv]
interface mbsed_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

interface mbsed_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [6:0] note_number;
  logic [6:0] note_velocity;
  logic [3:0] event_channel;

  modport source (output valid, output event_kind, output note_number,
                  output note_velocity, output event_channel, input ready);
  modport sink (input valid, input event_kind, input note_number,
                input note_velocity, input event_channel, output ready);
endinterface

interface mbsed_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_mask;

  modport source (output valid, output channel_mask, input ready);
  modport sink (input valid, input channel_mask, output ready);
endinterface

[src/midi_byte_stream_event_decoder_unit.sv]
// MIDI 1.0 byte stream event decoder.
// byte_i takes one raw byte of the serial stream per item. evt_o gives
// exactly one item per input byte: event kind, note, velocity and channel,
// with kind none (all other fields zero) for bytes that complete nothing.
// cfg_i writes the 16-bit channel mask; it is always ready, and a write
// takes effect for the next byte accepted.
// The event is registered: a byte accepted at an edge shows its event in
// the next cycle. Throughput is one byte per cycle while evt_o does not
// stall; the decode is a single pass through running status, first data
// byte and the mask between the input handshake and the event register.
// The event register decouples the sides: byte_i stays ready while the
// held event is taken in the same cycle. When evt_o stalls, byte_i drops
// ready until the pending event is taken; no byte or event is lost.
// Reset clears running status, the SysEx flag and the pending first data
// byte, empties the event register and sets the channel mask to all ones.
module midi_byte_stream_event_decoder_unit
  import mbsed_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  mbsed_byte_if.sink     byte_i,
  mbsed_cfg_if.sink      cfg_i,
  mbsed_evt_if.source    evt_o
);

  logic [15:0] mask_q;
  logic [7:0]  status_q, status_d;
  logic        have_first_q, have_first_d;
  logic [6:0]  first_q, first_d;
  logic        sysex_q, sysex_d;
  logic        out_valid_q;
  evt_t        evt_q, evt_d;
  logic        in_acc;
  logic        out_acc;
  logic [7:0]  b;
  logic        complete;
  logic [6:0]  d1;
  logic [6:0]  d2;
  logic        chan_on;

  assign b       = byte_i.midi_byte;
  assign in_acc  = byte_i.valid && byte_i.ready;
  assign out_acc = out_valid_q && evt_o.ready;
  assign byte_i.ready = !out_valid_q || evt_o.ready;
  assign cfg_i.ready  = 1'b1;
  assign chan_on = mask_q[status_q[3:0]];

  // State walk for one byte
  always_comb begin
    status_d     = status_q;
    have_first_d = have_first_q;
    first_d      = first_q;
    sysex_d      = sysex_q;
    complete     = 1'b0;
    d1           = first_q;
    d2           = b[6:0];
    if (b >= BYTE_REALTIME_MIN) begin
      // real-time: no effect
    end else if (b == BYTE_SYSEX_END) begin
      sysex_d = 1'b0;
    end else if (b == BYTE_SYSEX_START) begin
      sysex_d      = 1'b1;
      have_first_d = 1'b0;
    end else if (sysex_q) begin
      // absorb
    end else if (b >= BYTE_COMMON_MIN) begin
      status_d     = '0;
      have_first_d = 1'b0;
    end else if (b[7]) begin
      status_d     = b;
      have_first_d = 1'b0;
    end else if (status_q == '0) begin
      // drop data without status
    end else if (!have_first_q) begin
      if (status_q[7:4] == TYPE_PROGRAM || status_q[7:4] == TYPE_PRESSURE) begin
        // one-byte message completes with no event
      end else begin
        first_d      = b[6:0];
        have_first_d = 1'b1;
      end
    end else begin
      complete     = 1'b1;
      have_first_d = 1'b0;
    end
  end

  // Event decode of a completed two-byte message
  always_comb begin
    evt_d = '0;
    if (complete && chan_on) begin
      unique case (status_q[7:4])
        TYPE_NOTE_ON: begin
          evt_d.note_number = d1;
          if (d2 != '0) begin
            evt_d.event_kind    = KIND_NOTE_ON;
            evt_d.note_velocity = d2;
          end else begin
            evt_d.event_kind = KIND_NOTE_OFF;
          end
        end
        TYPE_NOTE_OFF: begin
          evt_d.event_kind  = KIND_NOTE_OFF;
          evt_d.note_number = d1;
        end
        TYPE_CTRL: begin
          if (d1 == CTRL_SUSTAIN) begin
            evt_d.event_kind = (d2 >= SUSTAIN_ON_MIN) ? KIND_SUSTAIN_ON
                                                      : KIND_SUSTAIN_OFF;
          end else if (d1 == CTRL_ALL_OFF) begin
            evt_d.event_kind = KIND_ALL_OFF;
          end
        end
        default: begin
          evt_d.event_kind = KIND_NONE;
        end
      endcase
      if (evt_d.event_kind != KIND_NONE) begin
        evt_d.event_channel = status_q[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= CHANNEL_MASK_RESET;
      status_q     <= '0;
      have_first_q <= 1'b0;
      first_q      <= '0;
      sysex_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        mask_q <= cfg_i.channel_mask;
      end
      if (in_acc) begin
        status_q     <= status_d;
        have_first_q <= have_first_d;
        first_q      <= first_d;
        sysex_q      <= sysex_d;
        out_valid_q  <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      evt_q <= evt_d;
    end
  end

  assign evt_o.valid         = out_valid_q;
  assign evt_o.event_kind    = evt_q.event_kind;
  assign evt_o.note_number   = evt_q.note_number;
  assign evt_o.note_velocity = evt_q.note_velocity;
  assign evt_o.event_channel = evt_q.event_channel;

  a_acc_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted byte produced no pending item");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && evt_q.event_kind == KIND_NONE) |->
      (evt_q.note_number == '0 && evt_q.note_velocity == '0 &&
       evt_q.event_channel == '0))
    else $error("kind none item carries nonzero fields");

  a_vel_only_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && evt_q.event_kind != KIND_NOTE_ON) |->
      evt_q.note_velocity == '0)
    else $error("velocity set on non note-on item");

  a_first_needs_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_first_q |-> status_q[7])
    else $error("first data byte held without running status");

  a_sysex_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && b == BYTE_SYSEX_START) |=> (sysex_q && !have_first_q))
    else $error("SysEx start not tracked");

endmodule
